// ===== rtl/core/prf_pkg.sv =====
// ----------------------------------------------------------------------------
// prf_pkg
// Shared types, codes and constants of the port rule packet filter.
// ----------------------------------------------------------------------------
package prf_pkg;

    // Default size of the rule table and the reset value of the proxy address.
    localparam int unsigned RULE_SLOTS_DEF = 16;
    localparam logic [31:0] PROXY_RESET    = 32'h8301_0101;  // 131.1.1.1

    localparam logic [7:0] PROTO_TCP = 8'd6;

    // Operation codes of an input word.
    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_DELETE   = 2'd1;
    localparam logic [1:0] OP_CLASSIFY = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    // Rule kinds and hook directions.
    localparam logic [2:0] KIND_INBOUND  = 3'd0;
    localparam logic [2:0] KIND_OUTBOUND = 3'd1;
    localparam logic [2:0] KIND_FORWARD  = 3'd2;
    localparam logic [2:0] KIND_PROXY    = 3'd3;

    // Result status codes.
    localparam logic [2:0] ST_ACCEPT  = 3'd0;
    localparam logic [2:0] ST_DROP    = 3'd1;
    localparam logic [2:0] ST_PROXIED = 3'd2;
    localparam logic [2:0] ST_ADDED   = 3'd3;
    localparam logic [2:0] ST_DELETED = 3'd4;
    localparam logic [2:0] ST_BADKIND = 3'd5;
    localparam logic [2:0] ST_FULL    = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH,
        S_OUTPUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the accepted word and restart the scan
        logic issue;   // read the next rule slot
        logic finish;  // commit an add to the table and form the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;        // the word on the input needs no table scan
        logic last_issue;  // the slot being read is the last one
    } t_sts;

    // One entry of the rule table.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] port;
        logic [15:0] id;
    } t_rule;

endpackage

// ===== rtl/core/prf_ctrl.sv =====
// ----------------------------------------------------------------------------
// prf_ctrl
// Sequencer of the packet filter: accepts a word, runs the table scan if it
// needs one, commits the result and holds it until the sink takes it.
// ----------------------------------------------------------------------------
module prf_ctrl
    import prf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = i_sts.skip ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:  n_state = S_FINISH;
            S_FINISH: n_state = S_OUTPUT;
            S_OUTPUT: begin
                if (i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready   = 1'b0;
        o_m_tvalid   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_SCAN:   o_cmd.issue  = 1'b1;
            S_DRAIN:  o_cmd        = '0;
            S_FINISH: o_cmd.finish = 1'b1;
            S_OUTPUT: o_m_tvalid   = 1'b1;
            default:  o_cmd        = '0;
        endcase
    end

endmodule

// ===== rtl/core/prf_dp.sv =====
// ----------------------------------------------------------------------------
// prf_dp
// Datapath of the packet filter: rule table, slot scan with one compare
// stage, checksum update and the result register.
// ----------------------------------------------------------------------------
module prf_dp
    import prf_pkg::*;
#(
    parameter int unsigned RULE_SLOTS = RULE_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic [1:0]  i_op,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_rule_port,
    input  logic [15:0] i_rule_id,
    input  logic [7:0]  i_protocol,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_hdr_checksum,
    output logic [2:0]  o_status,
    output logic [15:0] o_assigned_id,
    output logic [31:0] o_out_dst_addr,
    output logic [15:0] o_out_dst_port,
    output logic [15:0] o_out_checksum
);

    localparam int unsigned IW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int unsigned CW = $clog2(RULE_SLOTS + 1);

    // Captured word.
    logic [1:0]  r_op;
    logic [2:0]  r_kind;
    logic [15:0] r_rule_port;
    logic [15:0] r_rule_id;
    logic [7:0]  r_protocol;
    logic [15:0] r_src_port;
    logic [15:0] r_dst_port;
    logic [31:0] r_dst_addr;
    logic [15:0] r_hdr_checksum;
    logic [18:0] r_csum_sum;

    logic [31:0] r_proxy_addr;
    logic [15:0] r_last_id;

    t_rule              r_table [0:RULE_SLOTS-1];
    logic [RULE_SLOTS-1:0] r_active;

    // Scan pipeline: read stage and compare stage.
    logic [CW-1:0] r_idx;
    t_rule         r_rd;
    logic [IW-1:0] r_cmp_idx;
    logic          r_cmp_vld;

    logic          r_drop_hit;
    logic          r_proxy_hit;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;

    logic [2:0]  r_status;
    logic [15:0] r_assigned_id;
    logic [31:0] r_out_addr;
    logic [15:0] r_out_port;
    logic [15:0] r_out_csum;

    logic          cmp_act;
    logic [15:0]   drop_target;
    logic          drop_match;
    logic          proxy_match;
    logic [15:0]   next_id;
    logic [16:0]   fold_a;
    logic [15:0]   fold_b;

    // Words that need no scan: a bad add kind, a non-TCP packet, the unused op.
    always_comb begin
        o_sts.skip = 1'b0;
        case (i_op)
            OP_ADD:      o_sts.skip = (i_kind > KIND_PROXY);
            OP_DELETE:   o_sts.skip = 1'b0;
            OP_CLASSIFY: o_sts.skip = (i_protocol != PROTO_TCP);
            default:     o_sts.skip = 1'b1;
        endcase
        o_sts.last_issue = (r_idx == CW'(RULE_SLOTS - 1));
    end

    assign cmp_act     = r_active[r_cmp_idx];
    assign drop_target = (r_kind == KIND_INBOUND) ? r_src_port : r_dst_port;
    assign drop_match  = cmp_act && (r_kind <= KIND_FORWARD)
                         && (r_rd.kind == r_kind[1:0]) && (r_rd.port == drop_target);
    assign proxy_match = cmp_act && (r_rd.kind == KIND_PROXY[1:0])
                         && (r_rd.port == r_src_port);
    assign next_id     = r_last_id + 16'd1;

    // End-around carry fold of the one's complement sum; two passes suffice.
    assign fold_a = {1'b0, r_csum_sum[15:0]} + {14'd0, r_csum_sum[18:16]};
    assign fold_b = fold_a[15:0] + {15'd0, fold_a[16]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proxy_addr <= PROXY_RESET;
        end else if (i_cfg_wr_en) begin
            r_proxy_addr <= i_cfg_wr_data;
        end
    end

    // Captured word and the checksum partial sum (RFC 1624 style update).
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op           <= i_op;
            r_kind         <= i_kind;
            r_rule_port    <= i_rule_port;
            r_rule_id      <= i_rule_id;
            r_protocol     <= i_protocol;
            r_src_port     <= i_src_port;
            r_dst_port     <= i_dst_port;
            r_dst_addr     <= i_dst_addr;
            r_hdr_checksum <= i_hdr_checksum;
            r_csum_sum     <= {3'd0, ~i_hdr_checksum} + {3'd0, ~i_dst_addr[31:16]}
                              + {3'd0, ~i_dst_addr[15:0]} + {3'd0, r_proxy_addr[31:16]}
                              + {3'd0, r_proxy_addr[15:0]};
        end
    end

    // Rule table memory: one read port for the scan, one write port for adds.
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd <= r_table[r_idx[IW-1:0]];
        end
        if (i_cmd.finish && (r_op == OP_ADD) && (r_kind <= KIND_PROXY) && r_free_found) begin
            r_table[r_free_idx] <= '{kind: r_kind[1:0], port: r_rule_port, id: next_id};
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx[IW-1:0];
    end

    // Scan control, match flags, active marks and the id counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
            r_active     <= '0;
            r_last_id    <= '0;
            r_drop_hit   <= 1'b0;
            r_proxy_hit  <= 1'b0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
        end else begin
            r_cmp_vld <= i_cmd.issue;
            if (i_cmd.load) begin
                r_idx        <= '0;
                r_drop_hit   <= 1'b0;
                r_proxy_hit  <= 1'b0;
                r_free_found <= 1'b0;
            end else if (i_cmd.issue) begin
                r_idx <= r_idx + CW'(1);
            end
            if (r_cmp_vld) begin
                if (drop_match) begin
                    r_drop_hit <= 1'b1;
                end
                if (proxy_match) begin
                    r_proxy_hit <= 1'b1;
                end
                if (!cmp_act && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_cmp_idx;
                end
                if ((r_op == OP_DELETE) && cmp_act && (r_rd.id == r_rule_id)) begin
                    r_active[r_cmp_idx] <= 1'b0;
                end
            end
            if (i_cmd.finish && (r_op == OP_ADD) && (r_kind <= KIND_PROXY)
                && r_free_found) begin
                r_active[r_free_idx] <= 1'b1;
                r_last_id            <= next_id;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status      <= ST_ACCEPT;
            r_assigned_id <= '0;
            r_out_addr    <= '0;
            r_out_port    <= '0;
            r_out_csum    <= '0;
            case (r_op)
                OP_ADD: begin
                    if (r_kind > KIND_PROXY) begin
                        r_status <= ST_BADKIND;
                    end else if (!r_free_found) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_status      <= ST_ADDED;
                        r_assigned_id <= next_id;
                    end
                end
                OP_DELETE: begin
                    r_status <= ST_DELETED;
                end
                OP_CLASSIFY: begin
                    r_out_addr <= r_dst_addr;
                    r_out_port <= r_dst_port;
                    r_out_csum <= r_hdr_checksum;
                    if (r_protocol == PROTO_TCP) begin
                        if (r_drop_hit) begin
                            r_status <= ST_DROP;
                        end else if (r_proxy_hit) begin
                            r_status   <= ST_PROXIED;
                            r_out_addr <= r_proxy_addr;
                            r_out_port <= r_src_port;
                            r_out_csum <= ~fold_b;
                        end
                    end
                end
                default: begin
                    r_status <= ST_ACCEPT;
                end
            endcase
        end
    end

    assign o_status       = r_status;
    assign o_assigned_id  = r_assigned_id;
    assign o_out_dst_addr = r_out_addr;
    assign o_out_dst_port = r_out_port;
    assign o_out_checksum = r_out_csum;

endmodule

// ===== rtl/core/port_rule_packet_filter_unit.sv =====
// ----------------------------------------------------------------------------
// port_rule_packet_filter_unit
// Port rule table with add, delete and TCP packet classification, including
// proxy redirection with an incremental header checksum update.
// ----------------------------------------------------------------------------
//
//  Channel      Direction  Handshake              Content
//  s (input)    in         i_s_tvalid/o_s_tready  command or packet word
//  m (result)   out        o_m_tvalid/i_m_tready  one result word per input word
//  cfg          in         i_cfg_wr_en            proxy address, write only
//
// One word is processed at a time. A delete, a valid add and a TCP classify
// scan the rule table one slot per cycle through its single read port,
// then pass a drain state and a finish state that loads the result
// register. A bad add kind, a non-TCP packet and the unused op skip the
// scan and go straight to the finish state. The result is held until the
// sink takes it, and the next word is accepted in the cycle after that.
// Reset is synchronous and active low; it clears all active marks and the
// id counter and reloads the proxy address, so the table needs no
// clearing pass.
module port_rule_packet_filter_unit
    import prf_pkg::*;
#(
    parameter int unsigned RULE_SLOTS = RULE_SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // From bit 0: op[2], kind[3], rule_port[16], rule_id[16], protocol[8],
    // src_port[16], dst_port[16], dst_addr[32], hdr_checksum[16], zero fill.
    input  logic [127:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // From bit 0: status[3], assigned_id[16], out_dst_addr[32],
    // out_dst_port[16], out_checksum[16], zero fill.
    output logic [87:0]  o_m_tdata,
    input  logic         i_cfg_wr_en,
    input  logic [31:0]  i_cfg_wr_data
);

    t_cmd cmd;
    t_sts sts;

    logic [2:0]  status;
    logic [15:0] assigned_id;
    logic [31:0] out_dst_addr;
    logic [15:0] out_dst_port;
    logic [15:0] out_checksum;

    prf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The input word is unpacked here; the datapath only sees named fields.
    prf_dp #(
        .RULE_SLOTS (RULE_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_op           (i_s_tdata[1:0]),
        .i_kind         (i_s_tdata[4:2]),
        .i_rule_port    (i_s_tdata[20:5]),
        .i_rule_id      (i_s_tdata[36:21]),
        .i_protocol     (i_s_tdata[44:37]),
        .i_src_port     (i_s_tdata[60:45]),
        .i_dst_port     (i_s_tdata[76:61]),
        .i_dst_addr     (i_s_tdata[108:77]),
        .i_hdr_checksum (i_s_tdata[124:109]),
        .o_status       (status),
        .o_assigned_id  (assigned_id),
        .o_out_dst_addr (out_dst_addr),
        .o_out_dst_port (out_dst_port),
        .o_out_checksum (out_checksum)
    );

    assign o_m_tdata = {5'd0, out_checksum, out_dst_port, out_dst_addr, assigned_id, status};

endmodule
